FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/hdbn_pkg.sv
// ----------------------------------------------------------------------------
// hdbn_pkg
// types and symbol codes for the hdbn line encoder
// ----------------------------------------------------------------------------
`default_nettype none

package hdbn_pkg;

  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;

  // one stage of the symbol delay line
  typedef struct packed {
    logic              valid;
    logic              eom;
    logic signed [1:0] sym;
  } cell_t;

  // encoder head result for the current item
  typedef struct packed {
    logic signed [1:0] sym;
    logic              bal;
  } enc_t;

endpackage

`default_nettype wire

FILE: sv/hdbn_if.sv
// ----------------------------------------------------------------------------
// hdbn_if
// valid/ready channels for data bits in and line symbols out
// ----------------------------------------------------------------------------
`default_nettype none

interface hdbn_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic last_bit;

  modport source (output valid, output data_bit, output last_bit, input ready);
  modport sink (input valid, input data_bit, input last_bit, output ready);
endinterface

interface hdbn_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] line_symbol;
  logic              end_of_message;

  modport source (output valid, output line_symbol, output end_of_message, input ready);
  modport sink (input valid, input line_symbol, input end_of_message, output ready);
endinterface

`default_nettype wire

FILE: sv/hdbn_cell.sv
// ----------------------------------------------------------------------------
// hdbn_cell
// one stage of the symbol delay line, loads from its neighbour (the tail cell from the encoder) on shift
// ----------------------------------------------------------------------------
`default_nettype none

module hdbn_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          shift,
  input  wire hdbn_pkg::cell_t d,
  output hdbn_pkg::cell_t    q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q.valid <= d.valid;
    end
    if (shift) begin
      q.eom <= d.eom;
      q.sym <= d.sym;
    end
  end

endmodule

`default_nettype wire

FILE: sv/hdbn_enc.sv
// ----------------------------------------------------------------------------
// hdbn_enc
// head of the chain: pulse polarity, zero run count and violation choice
// ----------------------------------------------------------------------------
`default_nettype none

module hdbn_enc #(
  parameter int MAX_ZEROS = 2
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire logic    data_bit,
  input  wire logic    last_bit,
  input  wire logic    prior_viol,
  output hdbn_pkg::enc_t res
);

  localparam int ZW = $clog2(MAX_ZEROS + 1);

  logic [ZW-1:0] zero_run, zero_run_next;
  logic          next_pos, next_pos_next;
  logic          last_viol, last_viol_next;
  logic          at_start;
  logic          lv_eff;
  logic          viol_pos;

  always_comb begin
    lv_eff         = at_start ? prior_viol : last_viol;
    viol_pos       = !lv_eff;
    res.sym        = hdbn_pkg::SYM_ZERO;
    res.bal        = 1'b0;
    zero_run_next  = zero_run;
    next_pos_next  = next_pos;
    last_viol_next = lv_eff;
    if (data_bit) begin
      res.sym       = next_pos ? hdbn_pkg::SYM_POS : hdbn_pkg::SYM_NEG;
      next_pos_next = !next_pos;
      zero_run_next = '0;
    end else if (zero_run == ZW'(MAX_ZEROS)) begin
      res.sym        = viol_pos ? hdbn_pkg::SYM_POS : hdbn_pkg::SYM_NEG;
      res.bal        = (!next_pos) != viol_pos;
      next_pos_next  = !viol_pos;
      last_viol_next = viol_pos;
      zero_run_next  = '0;
    end else begin
      zero_run_next = zero_run + ZW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run  <= '0;
      next_pos  <= 1'b1;
      last_viol <= 1'b0;
      at_start  <= 1'b1;
    end else if (step) begin
      if (last_bit) begin
        zero_run <= '0;
        next_pos <= 1'b1;
        at_start <= 1'b1;
      end else begin
        zero_run <= zero_run_next;
        next_pos <= next_pos_next;
        at_start <= 1'b0;
      end
      last_viol <= last_viol_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/hdbn_line_encoder_top.sv
// ----------------------------------------------------------------------------
// hdbn_line_encoder_top
// hdbn line encoder: data bits in, ternary line symbols out
// ----------------------------------------------------------------------------
// one item per cycle unless the output stalls or the line drains; a symbol leaves
// MAX_ZEROS items after its bit, set by the MAX_ZEROS-cell delay line, and then
// passes through the output register; an item with last_bit set drains the line,
// and no item is taken until its symbol has left the last cell
// reset: line empty, start state, prior violation register cleared to 0
`default_nettype none
`include "assert_macros.svh"

module hdbn_line_encoder_top #(
  parameter int MAX_ZEROS = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  hdbn_in_if.sink     bit_in,
  hdbn_out_if.source  sym_out
);

  logic            prior_viol;
  logic            draining;
  logic            out_free;
  logic            acc;
  logic            drain_shift;
  logic            shift;
  logic            drain_done;
  hdbn_pkg::enc_t  enc;
  hdbn_pkg::cell_t new_cell;
  hdbn_pkg::cell_t chain [MAX_ZEROS];

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_viol <= 1'b0;
    end else if (cfg_we) begin
      prior_viol <= cfg_wdata;
    end
  end

  assign out_free     = !sym_out.valid || sym_out.ready;
  assign bit_in.ready = !draining && (out_free || !chain[0].valid);
  assign acc          = bit_in.valid && bit_in.ready;
  assign drain_shift  = draining && out_free;
  assign shift        = acc || drain_shift;
  assign drain_done   = drain_shift && chain[0].valid && chain[0].eom;

  hdbn_enc #(.MAX_ZEROS(MAX_ZEROS)) u_enc (
    .clk        (clk),
    .rst        (rst),
    .step       (acc),
    .data_bit   (bit_in.data_bit),
    .last_bit   (bit_in.last_bit),
    .prior_viol (prior_viol),
    .res        (enc)
  );

  always_comb begin
    new_cell.valid = acc;
    new_cell.eom   = bit_in.last_bit;
    new_cell.sym   = enc.sym;
  end

  for (genvar i = 0; i < MAX_ZEROS; i++) begin : g_cell
    if (i == MAX_ZEROS - 1) begin : g_tail
      hdbn_cell u_cell (
        .clk(clk), .rst(rst), .shift(shift), .d(new_cell), .q(chain[i])
      );
    end else begin : g_mid
      hdbn_cell u_cell (
        .clk(clk), .rst(rst), .shift(shift), .d(chain[i+1]), .q(chain[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (acc && bit_in.last_bit) begin
      draining <= 1'b1;
    end else if (drain_done) begin
      draining <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_out.valid <= 1'b0;
    end else if (shift && chain[0].valid) begin
      sym_out.valid <= 1'b1;
    end else if (sym_out.ready) begin
      sym_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift && chain[0].valid) begin
      // balancing pulse over the first zero of the run
      sym_out.line_symbol    <= (acc && enc.bal) ? enc.sym : chain[0].sym;
      sym_out.end_of_message <= chain[0].eom;
    end
  end

  `ASSERT_IMP(a_no_take_in_drain, clk, rst, draining, !bit_in.ready)
  `ASSERT_NXT(a_last_starts_drain, clk, rst, acc && bit_in.last_bit, draining)
  `ASSERT_NXT(a_drain_ends_eom, clk, rst, drain_done,
              !draining && sym_out.valid && sym_out.end_of_message)

endmodule

`default_nettype wire
